FILE: sv/itx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itx_pkg
// Shared types and constants of the image TLV hash extractor.
// ----------------------------------------------------------------------------
package itx_pkg;

    localparam int MAX_IMAGE_BYTES = 524288;
    localparam int ADDR_W          = $clog2(MAX_IMAGE_BYTES);
    localparam int CNT_W           = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int POS_W           = 34;

    localparam logic [31:0] MAGIC_WORD = 32'h96f3b83c;
    localparam logic [15:0] HASH_TAG   = 16'h0010;
    localparam logic [15:0] HASH_LEN   = 16'h0020;
    localparam logic [2:0]  MAGIC_SKIP = 3'd4;
    localparam logic [4:0]  HASH_LAST  = 5'd31;

    localparam logic [1:0] STAT_FOUND     = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_TOO_LARGE = 2'd2;

    localparam logic KIND_HASH   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CAPTURE,
        ST_CHECK,
        ST_HASH_OUT,
        ST_STATUS_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HSIZE,
        PH_DSIZE,
        PH_TAG,
        PH_LEN,
        PH_HASH
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] hash_byte;
        logic [4:0] hash_index;
        logic [1:0] status;
        logic       last;
    } res_t;

endpackage

FILE: sv/itx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itx_ram
// Image byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itx_ram
    import itx_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MAX_IMAGE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/itx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itx_ctrl
// Load counter and TLV walk sequencer around one byte reader.
// ----------------------------------------------------------------------------
module itx_ctrl
    import itx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [7:0]        mem_rdata
);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        rem_reg, rem_next;
    logic [31:0]       acc_reg, acc_next;
    logic              magic_ok_reg, magic_ok_next;
    logic [15:0]       tag_reg, tag_next;
    logic [4:0]        hidx_reg, hidx_next;
    logic [7:0]        hbyte_reg, hbyte_next;
    logic [1:0]        stat_reg, stat_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [POS_W-1:0]  cnt_ext;
    logic [POS_W-1:0]  rd_inc;
    logic [7:0]        byte_v;
    logic [31:0]       acc_sh;
    logic [CNT_W-1:0]  cnt_inc;
    logic              accept;

    assign cnt_ext = POS_W'(cnt_reg);
    assign rd_inc  = rd_pos_reg + POS_W'(1);
    assign byte_v  = rd_ok_reg ? mem_rdata : 8'd0;
    assign acc_sh  = {byte_v, acc_reg[31:8]};
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign accept  = in_valid && in_ready;

    assign in_ready  = (state_reg == ST_LOAD);
    assign mem_we    = accept && !ovf_reg;
    assign mem_waddr = cnt_reg[ADDR_W-1:0];
    assign mem_wdata = in_byte;
    assign mem_raddr = rd_pos_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
        phase_reg    <= phase_next;
        rd_pos_reg   <= rd_pos_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        magic_ok_reg <= magic_ok_next;
        tag_reg      <= tag_next;
        hidx_reg     <= hidx_next;
        hbyte_reg    <= hbyte_next;
        stat_reg     <= stat_next;
        rd_ok_reg    <= rd_ok_next;
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        rd_pos_next   = rd_pos_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        magic_ok_next = magic_ok_reg;
        tag_next      = tag_reg;
        hidx_next     = hidx_reg;
        hbyte_next    = hbyte_reg;
        stat_next     = stat_reg;
        rd_ok_next    = rd_ok_reg;
        res_valid     = 1'b0;
        res           = '0;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (!ovf_reg) begin
                        cnt_next = cnt_inc;
                        ovf_next = (cnt_inc >= CNT_W'(MAX_IMAGE_BYTES));
                    end
                    if (in_end) begin
                        if (!ovf_reg && (cnt_inc < CNT_W'(MAX_IMAGE_BYTES))) begin
                            phase_next  = PH_MAGIC;
                            rd_pos_next = '0;
                            rem_next    = 3'd4;
                            state_next  = ST_FETCH;
                        end else begin
                            stat_next  = STAT_TOO_LARGE;
                            state_next = ST_STATUS_OUT;
                        end
                    end
                end
            end
            ST_FETCH: begin
                rd_ok_next = (rd_pos_reg < cnt_ext);
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                acc_next    = acc_sh;
                rd_pos_next = rd_inc;
                rem_next    = rem_reg - 3'd1;
                state_next  = ST_FETCH;
                if (rem_reg == 3'd1) begin
                    case (phase_reg)
                        PH_MAGIC: begin
                            magic_ok_next = (acc_sh == MAGIC_WORD);
                            rd_pos_next   = POS_W'(8);
                            rem_next      = 3'd4;
                            phase_next    = PH_HSIZE;
                        end
                        PH_HSIZE: begin
                            pos_next   = POS_W'(acc_sh);
                            rem_next   = 3'd4;
                            phase_next = PH_DSIZE;
                        end
                        PH_DSIZE: begin
                            pos_next = pos_reg + POS_W'(acc_sh)
                                     + (magic_ok_reg ? '0 : POS_W'(MAGIC_SKIP));
                            state_next = ST_CHECK;
                        end
                        PH_TAG: begin
                            tag_next   = acc_sh[31:16];
                            rem_next   = 3'd2;
                            phase_next = PH_LEN;
                        end
                        PH_LEN: begin
                            if (tag_reg == HASH_TAG && acc_sh[31:16] == HASH_LEN) begin
                                hidx_next  = '0;
                                rem_next   = 3'd1;
                                phase_next = PH_HASH;
                            end else begin
                                pos_next   = rd_inc + POS_W'(acc_sh[31:16]);
                                state_next = ST_CHECK;
                            end
                        end
                        PH_HASH: begin
                            hbyte_next = byte_v;
                            state_next = ST_HASH_OUT;
                        end
                        default: begin
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (pos_reg < cnt_ext) begin
                    rd_pos_next = pos_reg;
                    rem_next    = 3'd2;
                    phase_next  = PH_TAG;
                    state_next  = ST_FETCH;
                end else begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = ST_STATUS_OUT;
                end
            end
            ST_HASH_OUT: begin
                res_valid      = 1'b1;
                res.kind       = KIND_HASH;
                res.hash_byte  = hbyte_reg;
                res.hash_index = hidx_reg;
                if (res_ready) begin
                    if (hidx_reg == HASH_LAST) begin
                        stat_next  = STAT_FOUND;
                        state_next = ST_STATUS_OUT;
                    end else begin
                        hidx_next  = hidx_reg + 5'd1;
                        rem_next   = 3'd1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_STATUS_OUT: begin
                res_valid  = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = stat_reg;
                res.last   = 1'b1;
                if (res_ready) begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: sv/image_tlv_hash_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_tlv_hash_extractor
// Loads a firmware image and extracts the SHA-256 hash from its TLV area.
// ----------------------------------------------------------------------------
// Input stream: one image byte per beat on s_tdata, s_tlast on the final
// byte. Loading takes one beat per cycle into a simple dual-port byte store.
// Bytes past the store capacity are dropped and the run reports too large.
// After the final beat the input is held off (s_tready low) while the
// sequencer reads the header and walks the TLV records, one byte at a
// time through the store's registered read port (a fetch state, then a
// capture state): the header, then per record a position check plus tag
// and length, then each hash byte with its own result beat, and one
// status beat. Results leave through an output register: 32 hash beats
// then a status beat with m_tlast, or a single status beat. A stalled
// receiver holds the walk at the next result. Reset (aresetn low, sync)
// returns to loading with an empty count; the store needs no clearing.
// ----------------------------------------------------------------------------
module image_tlv_hash_extractor
    import itx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] hash_byte, [12:8] hash_index, [14:13] status
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast
);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic              m_valid_reg;
    res_t              m_res_reg;

    itx_ram u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    itx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.status, m_res_reg.hash_index, m_res_reg.hash_byte};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

    a_hash_beat_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == KIND_HASH) |-> (!m_tlast && m_tdata[14:13] == 2'd0))
        else $error("hash beat carries status or last");

    a_status_beat_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == KIND_STATUS)
            |-> (m_tlast && m_tdata[12:0] == 13'd0 && m_tdata[14:13] != 2'd3))
        else $error("malformed status beat");

    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after end of image");

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !mem_we)
        else $error("store written while walking");

endmodule

FILE: dv/itx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itx_checker
// Watches both streams of the image TLV hash extractor, keeps its own copy of
// the loaded image, predicts the hash and status beats of every run and
// compares them in order with what leaves the block.
// ----------------------------------------------------------------------------
module itx_checker
    import itx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] hash_byte, [12:8] hash_index, [14:13] status
    input  logic [0:0]  m_tuser,   // [0] kind
    input  logic        m_tlast,
    output int          err_count,
    output int          pending
);

    bit [7:0]    image_copy [MAX_IMAGE_BYTES];
    int unsigned bytes_held;
    bit          capacity_hit;
    res_t        expected_results[$];

    initial begin
        err_count = 0;
        pending   = 0;
    end

    // reads at or past the loaded length give zero
    function automatic logic [7:0] image_byte(input longint unsigned p);
        if (p >= bytes_held || p >= MAX_IMAGE_BYTES) begin
            return 8'h00;
        end
        return image_copy[int'(p)];
    endfunction

    function automatic logic [31:0] image_le(input longint unsigned p, input int nb);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < nb; i++) begin
            v[8*i +: 8] = image_byte(p + i);
        end
        return v;
    endfunction

    task automatic predict_tlv_walk();
        logic [31:0]     magic;
        logic [31:0]     tag;
        logic [31:0]     len;
        longint unsigned pos;
        res_t            r;
        magic = image_le(0, 4);
        pos   = image_le(8, 4);
        pos   = pos + image_le(12, 4);
        if (magic != MAGIC_WORD) begin
            pos = pos + MAGIC_SKIP;
        end
        while (pos < bytes_held) begin
            tag = image_le(pos, 2);
            len = image_le(pos + 2, 2);
            pos = pos + 4;
            if (tag == 32'(HASH_TAG) && len == 32'(HASH_LEN)) begin
                for (int i = 0; i < int'(HASH_LEN); i++) begin
                    r            = '0;
                    r.kind       = KIND_HASH;
                    r.hash_byte  = image_byte(pos + i);
                    r.hash_index = 5'(i);
                    expected_results.push_back(r);
                end
                r        = '0;
                r.kind   = KIND_STATUS;
                r.status = STAT_FOUND;
                r.last   = 1'b1;
                expected_results.push_back(r);
                return;
            end
            pos = pos + len;
        end
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = STAT_NOT_FOUND;
        r.last   = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        res_t r;
        if (!aresetn) begin
            bytes_held   = 0;
            capacity_hit = 1'b0;
            expected_results.delete();
            pending      = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (!capacity_hit && bytes_held < MAX_IMAGE_BYTES) begin
                    image_copy[bytes_held] = s_tdata;
                    bytes_held++;
                    if (bytes_held >= MAX_IMAGE_BYTES) begin
                        capacity_hit = 1'b1;
                    end
                end
                if (s_tlast) begin
                    if (capacity_hit) begin
                        r        = '0;
                        r.kind   = KIND_STATUS;
                        r.status = STAT_TOO_LARGE;
                        r.last   = 1'b1;
                        expected_results.push_back(r);
                    end else begin
                        predict_tlv_walk();
                    end
                    bytes_held   = 0;
                    capacity_hit = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: tdata %h tuser %h tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    err_count++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("kind", r.kind, m_tuser[0]);
                    check_field("hash_byte", r.hash_byte, m_tdata[7:0]);
                    check_field("hash_index", r.hash_index, m_tdata[12:8]);
                    check_field("status", r.status, m_tdata[14:13]);
                    check_field("last", r.last, m_tlast);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the image TLV hash extractor bench. Streams small directed and
// random firmware images (well-formed TLV layouts, decoy records, truncated
// and noise images) with random gaps and receiver stalls; the checker
// predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;
    import itx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int          fail_cnt;
    int          exp_pending;
    int          cycle_cnt = 0;

    logic [7:0]  img_bytes[$];
    bit          src_steady;
    int          random_beats;
    int          img_count;

    image_tlv_hash_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    itx_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .err_count (fail_cnt),
        .pending   (exp_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic e);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_image();
        src_steady = ($urandom_range(0, 3) == 0);
        foreach (img_bytes[i]) begin
            push_beat(img_bytes[i], i == img_bytes.size() - 1);
        end
    endtask

    // sender stays quiet until every predicted beat has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (exp_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic put_le(input logic [31:0] w, input int nb);
        for (int i = 0; i < nb; i++) begin
            img_bytes.push_back(w[8*i +: 8]);
        end
    endtask

    task automatic put_random(input int n);
        repeat (n) img_bytes.push_back(8'($urandom));
    endtask

    task automatic build_image(input bit with_hash);
        int          sel;
        int          hsize;
        int          dsize;
        int          len;
        int          cut;
        logic [15:0] tag;
        bit          good_magic;
        img_bytes.delete();
        sel = $urandom_range(0, 99);
        if (!with_hash && sel < 15) begin
            put_random($urandom_range(1, 20));
            return;
        end
        good_magic = with_hash || ($urandom_range(0, 3) != 0);
        // some headers too short, so the walk starts inside the header
        hsize = (!with_hash && sel < 25) ? $urandom_range(0, 15) : $urandom_range(16, 20);
        dsize = $urandom_range(0, 4);
        put_le(good_magic ? MAGIC_WORD : 32'($urandom), 4);
        put_le($urandom, 4);
        put_le(hsize, 4);
        put_le(dsize, 4);
        while (img_bytes.size() < hsize + dsize) img_bytes.push_back(8'($urandom));
        if (!good_magic) begin
            put_random(4);
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0: begin
                    tag = 16'($urandom);
                    len = $urandom_range(0, 6);
                end
                1: begin
                    tag = HASH_TAG;
                    len = $urandom_range(0, 6);
                end
                default: begin
                    tag = 16'($urandom);
                    len = int'(HASH_LEN);
                end
            endcase
            if (tag == HASH_TAG && len == int'(HASH_LEN)) begin
                tag = tag ^ 16'h0100;
            end
            put_le(32'(tag), 2);
            put_le(len, 2);
            put_random(len);
        end
        if (with_hash || $urandom_range(0, 3) != 0) begin
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
                put_le(32'(HASH_TAG), 2);
                put_le(32'(HASH_LEN), 2);
                put_random(int'(HASH_LEN));
            end
        end
        put_random($urandom_range(0, 3));
        if (!with_hash && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, img_bytes.size() - 1);
            repeat (cut) void'(img_bytes.pop_back());
        end
    endtask

    // receiver: random stalls, calm stretches, one long hold-off
    initial begin : receiver
        int rx_beats;
        int stall;
        bit held;
        rx_beats = 0;
        held     = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ((rx_beats / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            rx_beats++;
            if (rx_beats == 20 && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
        end
    end

    initial begin
        random_beats = 0;
        img_count    = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte images, header pointing far past the end, short header
        img_bytes.delete();
        put_le(32'h00, 1);
        send_image();
        img_bytes.delete();
        put_le(32'hFF, 1);
        send_image();
        img_bytes.delete();
        put_le(MAGIC_WORD, 4);
        put_le('1, 4);
        put_le('1, 4);
        put_le('1, 4);
        send_image();
        img_bytes.delete();
        put_le('1, 4);
        send_image();
        wait_drained();

        build_image(1'b1);
        send_image();
        random_beats += img_bytes.size();
        while (random_beats < 310) begin
            build_image(1'b0);
            send_image();
            random_beats += img_bytes.size();
            img_count++;
            if (img_count % 5 == 0) begin
                wait_drained();
            end
        end
        wait_drained();

        repeat (200) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/itx_pkg.sv
sv/itx_ram.sv
sv/itx_ctrl.sv
sv/image_tlv_hash_extractor.sv
dv/itx_checker.sv
dv/tb.sv
